>>> hdl/vss_pkg.sv
// Shared types and constants for the voltammetry sweep sequencer.
// Used by every module of the block but vss_checker; no dependencies of its own.

package vss_pkg;

  // Configuration register indexes, in port order.
  typedef enum logic [2:0] {
    CFG_SWEEP_MODE  = 3'd0,
    CFG_START_UV    = 3'd1,
    CFG_TARGET_UV   = 3'd2,
    CFG_STEP_UV     = 3'd3,
    CFG_INITIAL_UV  = 3'd4,
    CFG_CYCLE_LIMIT = 3'd5,
    CFG_GAIN_RANGE  = 3'd6
  } cfg_index_t;

  // Sweep mode codes; the remaining codes only report.
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CYCLIC = 2'd2;

  // Current range codes.
  localparam logic [1:0] GAIN_HOLD = 2'd0;
  localparam logic [1:0] GAIN_LOW  = 2'd1;
  localparam logic [1:0] GAIN_MID  = 2'd2;
  localparam logic [1:0] GAIN_HIGH = 2'd3;

  // Item kinds on the input stream.
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam int CFG_DATA_W = 23;
  localparam int POT_W      = 24;
  localparam int MV_W       = 13;
  localparam int CUR_W      = 18;
  localparam int ADC_W      = 16;

  // Fixed-point constants, microvolts.
  localparam logic signed [24:0] DAC_OFFSET_UV  = 25'sd2700000;
  localparam logic signed [25:0] TURN_MARGIN_UV = 26'sd100;
  localparam logic signed [39:0] LIN_SCALE      = 40'sd10000;
  // Eight times the 2.5 V mid-scale and eight times one converter code.
  localparam logic signed [26:0] ADC_MID_X8     = 27'sd20000000;
  localparam logic [9:0]         ADC_LSB_X8     = 10'd625;

  // Millivolt rounding: divide by 1000 through a reciprocal, exact below 2^24.
  localparam logic [23:0] MV_HALF  = 24'd500;
  localparam logic [24:0] MV_RECIP = 25'd17179870;
  localparam int          MV_SHIFT = 34;

  // Current ranges: divisors 8*15000, 8*146 and 8*20, exact below 2^25.
  localparam logic [15:0] CUR_HALF_LOW   = 16'd60000;
  localparam logic [15:0] CUR_HALF_MID   = 16'd584;
  localparam logic [15:0] CUR_HALF_HIGH  = 16'd80;
  localparam logic [25:0] CUR_RECIP_LOW  = 26'd36650388;
  localparam logic [25:0] CUR_RECIP_MID  = 26'd58835169;
  localparam logic [25:0] CUR_RECIP_HIGH = 26'd53687092;
  localparam int          CUR_SHIFT_LOW  = 42;
  localparam int          CUR_SHIFT_MID  = 36;
  localparam int          CUR_SHIFT_HIGH = 33;

  typedef struct packed {
    logic [1:0]         sweep_mode;
    logic signed [22:0] start_uv;
    logic signed [22:0] target_uv;
    logic [19:0]        step_uv;
    logic signed [22:0] initial_uv;
    logic [7:0]         cycle_limit;
    logic [1:0]         gain_range;
  } cfg_t;

  // One result between the sweep stage and the scaling stage.
  typedef struct packed {
    logic [POT_W-1:0] dac;
    logic             mv_neg;
    logic [23:0]      mv_mag;
    logic             cur_neg;
    logic [24:0]      cur_mag;
    logic             conv;
    logic             running;
  } prep_t;

endpackage

>>> hdl/vss_cfg_regs.sv
// Configuration register file of the voltammetry sweep sequencer.
// Depends on vss_pkg for the register indexes and the cfg_t bundle.

module vss_cfg_regs
  import vss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sweep_mode  <= 2'd0;
      cfg.start_uv    <= 23'sd0;
      cfg.target_uv   <= 23'sd0;
      cfg.step_uv     <= 20'd0;
      cfg.initial_uv  <= 23'sd0;
      cfg.cycle_limit <= 8'd1;
      cfg.gain_range  <= GAIN_LOW;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SWEEP_MODE:  cfg.sweep_mode  <= cfg_data[1:0];
        CFG_START_UV:    cfg.start_uv    <= cfg_data;
        CFG_TARGET_UV:   cfg.target_uv   <= cfg_data;
        CFG_STEP_UV:     cfg.step_uv     <= cfg_data[19:0];
        CFG_INITIAL_UV:  cfg.initial_uv  <= cfg_data;
        CFG_CYCLE_LIMIT: cfg.cycle_limit <= cfg_data[7:0];
        CFG_GAIN_RANGE:  cfg.gain_range  <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/vss_sweep.sv
// Input register, sweep state and the first result stage of the sequencer.
// Depends on vss_pkg; feeds vss_scale through a registered prep_t bundle.

module vss_sweep
  import vss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [ADC_W-1:0] in_code,
  output logic             prep_valid,
  input  logic             prep_ready,
  output prep_t            prep
);

  logic             hold_valid;
  logic             hold_action;
  logic [ADC_W-1:0] hold_code;

  logic signed [POT_W-1:0] potential, potential_next;
  logic                    forward, forward_next;
  logic [7:0]              cycles_done, cycles_done_next;
  logic                    active, active_next;

  logic                    adv, take, is_sample, stepping;
  logic signed [25:0]      pot_ext, start_ext, target_ext, step_ext;
  logic signed [25:0]      pot_up, pot_dn, lin_diff, raw;
  logic signed [39:0]      lin_scaled;
  logic                    turn_hi, turn_lo, lin_end;
  logic [7:0]              cyc_inc;
  logic signed [24:0]      pot25, dac25, mv_abs;
  logic signed [26:0]      num;
  logic [25:0]             cur_abs;
  logic [15:0]             cur_half;
  prep_t                   prep_next;

  assign adv      = !prep_valid || prep_ready;
  assign in_ready = !hold_valid || adv;
  assign take     = hold_valid && adv;
  assign is_sample = (hold_action == ACT_SAMPLE);
  assign stepping  = (cfg.sweep_mode == MODE_LINEAR) || (cfg.sweep_mode == MODE_CYCLIC);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hold_action <= in_action;
      hold_code   <= in_code;
    end
  end

  // Step arithmetic, wide enough that no sum wraps before saturation.
  assign pot_ext    = {{2{potential[POT_W-1]}}, potential};
  assign start_ext  = {{3{cfg.start_uv[22]}}, cfg.start_uv};
  assign target_ext = {{3{cfg.target_uv[22]}}, cfg.target_uv};
  assign step_ext   = {6'd0, cfg.step_uv};
  assign pot_up     = pot_ext + step_ext;
  assign pot_dn     = pot_ext - step_ext;
  assign turn_hi    = pot_up > (target_ext - TURN_MARGIN_UV);
  assign turn_lo    = pot_dn < (start_ext + TURN_MARGIN_UV);
  assign cyc_inc    = cycles_done + 8'd1;
  // 10000 * p > 10001 * t is the same as 10000 * (p - t) > t.
  assign lin_diff   = pot_up - target_ext;
  assign lin_scaled = $signed({{14{lin_diff[25]}}, lin_diff}) * LIN_SCALE;
  assign lin_end    = lin_scaled > $signed({{14{target_ext[25]}}, target_ext});

  always_comb begin
    potential_next   = potential;
    forward_next     = forward;
    cycles_done_next = cycles_done;
    active_next      = active;
    raw              = pot_ext;
    if (take) begin
      if (!is_sample) begin
        potential_next   = {cfg.initial_uv[22], cfg.initial_uv};
        forward_next     = 1'b1;
        cycles_done_next = 8'd0;
        active_next      = 1'b1;
      end else if (active && stepping) begin
        if (cfg.sweep_mode == MODE_CYCLIC) begin
          if (forward) begin
            raw = pot_up;
            if (turn_hi) begin
              forward_next = 1'b0;
            end
          end else begin
            raw = pot_dn;
            if (turn_lo) begin
              forward_next     = 1'b1;
              cycles_done_next = cyc_inc;
              if (cyc_inc >= cfg.cycle_limit) begin
                active_next      = 1'b0;
                cycles_done_next = 8'd0;
              end
            end
          end
        end else begin
          raw = pot_up;
          if (lin_end) begin
            active_next      = 1'b0;
            cycles_done_next = 8'd0;
          end
        end
        if (raw > 26'sd8388607) begin
          potential_next = 24'sh7FFFFF;
        end else if (raw < -26'sd8388608) begin
          potential_next = 24'sh800000;
        end else begin
          potential_next = raw[POT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      potential   <= '0;
      forward     <= 1'b1;
      cycles_done <= 8'd0;
      active      <= 1'b0;
    end else begin
      potential   <= potential_next;
      forward     <= forward_next;
      cycles_done <= cycles_done_next;
      active      <= active_next;
    end
  end

  // Result fields from the potential before stepping, and the current
  // numerator brought to magnitude plus half the divisor.
  always_comb begin
    case (cfg.gain_range)
      GAIN_LOW:  cur_half = CUR_HALF_LOW;
      GAIN_MID:  cur_half = CUR_HALF_MID;
      GAIN_HIGH: cur_half = CUR_HALF_HIGH;
      default:   cur_half = 16'd0;
    endcase
  end

  assign pot25   = {potential[POT_W-1], potential};
  assign dac25   = DAC_OFFSET_UV - pot25;
  assign mv_abs  = potential[POT_W-1] ? -pot25 : pot25;
  assign num     = ADC_MID_X8 - $signed({1'b0, 26'({10'd0, hold_code} * ADC_LSB_X8)});
  assign cur_abs = num[26] ? 26'(-num) : num[25:0];

  always_comb begin
    prep_next.dac     = dac25[POT_W-1:0];
    prep_next.mv_neg  = potential[POT_W-1];
    prep_next.mv_mag  = mv_abs[23:0] + MV_HALF;
    prep_next.cur_neg = num[26];
    prep_next.cur_mag = 25'(cur_abs + {10'd0, cur_half});
    prep_next.conv    = stepping && (cfg.gain_range != GAIN_HOLD);
    prep_next.running = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (adv) begin
      prep_valid <= take && is_sample && active;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep <= prep_next;
    end
  end

endmodule

>>> hdl/vss_scale.sv
// Scaling stage and result register of the sequencer: reciprocal multiplies
// for the millivolt and current fields, and the held current. Uses vss_pkg.

module vss_scale
  import vss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       gain_range,
  input  logic             prep_valid,
  output logic             prep_ready,
  input  prep_t            prep,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POT_W-1:0] out_dac,
  output logic [MV_W-1:0]  out_mv,
  output logic [CUR_W-1:0] out_cur,
  output logic             out_running
);

  logic [48:0]      mv_prod;
  logic [14:0]      mv_q;
  logic [MV_W-1:0]  mv_val;
  logic [25:0]      recip;
  logic [59:0]      cur_prod;
  logic [CUR_W-1:0] cur_q, cur_val, cur_next;
  logic [CUR_W-1:0] held_current;
  logic             load;

  assign prep_ready = !out_valid || out_ready;
  assign load       = prep_valid && prep_ready;

  assign mv_prod = {25'd0, prep.mv_mag} * {24'd0, MV_RECIP};
  assign mv_q    = mv_prod[MV_SHIFT +: 15];

  // Saturate to the 13-bit millivolt field.
  always_comb begin
    if (mv_q >= 15'd4096) begin
      mv_val = prep.mv_neg ? 13'h1000 : 13'h0FFF;
    end else if (prep.mv_neg) begin
      mv_val = 13'(-mv_q);
    end else begin
      mv_val = mv_q[MV_W-1:0];
    end
  end

  always_comb begin
    case (gain_range)
      GAIN_LOW:  recip = CUR_RECIP_LOW;
      GAIN_MID:  recip = CUR_RECIP_MID;
      GAIN_HIGH: recip = CUR_RECIP_HIGH;
      default:   recip = 26'd0;
    endcase
  end

  assign cur_prod = {35'd0, prep.cur_mag} * {34'd0, recip};

  always_comb begin
    case (gain_range)
      GAIN_LOW:  cur_q = cur_prod[CUR_SHIFT_LOW +: CUR_W];
      GAIN_MID:  cur_q = cur_prod[CUR_SHIFT_MID +: CUR_W];
      GAIN_HIGH: cur_q = cur_prod[CUR_SHIFT_HIGH +: CUR_W];
      default:   cur_q = '0;
    endcase
  end

  assign cur_val  = prep.cur_neg ? -cur_q : cur_q;
  assign cur_next = prep.conv ? cur_val : held_current;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      held_current <= '0;
    end else begin
      if (prep_ready) begin
        out_valid <= prep_valid;
      end
      if (load) begin
        held_current <= cur_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_dac     <= prep.dac;
      out_mv      <= mv_val;
      out_cur     <= cur_next;
      out_running <= prep.running;
    end
  end

endmodule

>>> hdl/voltammetry_sweep_sequencer.sv
// Top level of the voltammetry sweep sequencer: stream ports and packing.
// Instantiates vss_cfg_regs, vss_sweep and vss_scale; uses vss_pkg.

// The sequencer accepts one request per clock cycle when nothing stalls and
// returns a result through the input, prep and result registers. A start
// request (tuser 0) loads the initial potential, sets the sweep direction
// forward and clears the cycle count; it returns nothing. A sample request
// (tuser 1) taken while a run is active returns the DAC setpoint (2.7 V
// minus the potential, in microvolts), the potential before the step in
// rounded millivolts, and the cell current from the converter code in the
// selected gain range (the held one in the hold range or a report mode),
// then steps the potential in linear and cyclic mode. Samples taken with
// no run active are dropped. The result with tlast high is the last of its
// run. The rate is set by the potential update in vss_sweep; the current
// and millivolt divisions are reciprocal multiplies in the following
// stage. Registers are written through the cfg port, which is always
// ready, and should only be changed while no request is in flight.

module voltammetry_sweep_sequencer
  import vss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [15:0] adc_code
  input  logic [0:0]            s_axis_tuser,  // [0] action
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,  // [23:0] dac_setpoint_uv, [36:24]
                                               // potential_mv, [54:37] current_report
  output logic                  m_axis_tlast,  // high when the run has ended
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  prep_t            prep;
  logic             prep_valid, prep_ready;
  logic [POT_W-1:0] out_dac;
  logic [MV_W-1:0]  out_mv;
  logic [CUR_W-1:0] out_cur;
  logic             out_running;

  vss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The sweep stage owns the potential, direction, cycle count and run flag.
  vss_sweep u_sweep (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser[0]),
    .in_code    (s_axis_tdata),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep       (prep)
  );

  // The scaling stage finishes the divisions and holds the last current.
  vss_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .gain_range  (cfg.gain_range),
    .prep_valid  (prep_valid),
    .prep_ready  (prep_ready),
    .prep        (prep),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_dac     (out_dac),
    .out_mv      (out_mv),
    .out_cur     (out_cur),
    .out_running (out_running)
  );

  assign m_axis_tdata = {1'b0, out_cur, out_mv, out_dac};
  assign m_axis_tlast = !out_running;

endmodule

>>> hdl/vss_checker.sv
// Port-level checks for the voltammetry sweep sequencer, bound to the top.
// Needs only the top level's handshake and result ports.

module vss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result keeps its value and its end-of-run mark.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

  // With the result side free, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while result side was free");

  // Register writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind voltammetry_sweep_sequencer vss_checker u_vss_checker (.*);

>>> tb/tb_voltammetry_sweep_sequencer.sv
`timescale 1ns / 100ps
// Self-checking testbench for voltammetry_sweep_sequencer: directed and random sweep
// requests, with stalls on both streams, checked against a predictor of the sweep.
// Depends on vss_pkg and the block's RTL; it reads no files.

module tb_voltammetry_sweep_sequencer;
  import vss_pkg::*;

  localparam int LIMIT_CYCLES   = 1000000;
  localparam int ITEM_TARGET    = 1500;
  // A sample comes out through the input, prep and result registers; leave a
  // little more before touching the registers.
  localparam int DRAIN_CYCLES   = 8;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int MAX_REPORTS    = 10;

  // Mode codes that only report; the package names just the two sweeping ones.
  localparam logic [1:0] MODE_REPORT     = 2'd0;
  localparam logic [1:0] MODE_REPORT_ALT = 2'd3;

  // One result as the block packs it, running taken as the inverse of tlast.
  typedef struct packed {
    logic signed [23:0] dac;
    logic signed [12:0] mv;
    logic signed [17:0] cur;
    logic               running;
  } sweep_report_t;

  // Tracks the sweep state and register settings, and keeps the reports that
  // accepted sample requests are due to produce, oldest first.
  class sweep_checker;
    cfg_t            settings;
    longint          potential;
    bit              forward;
    int              cycles_done;
    bit              run_active;
    longint          held_current;
    sweep_report_t   expected_reports[$];
    int              errors;
    int              checked;

    function new();
      settings             = '0;
      settings.cycle_limit = 8'd1;
      settings.gain_range  = GAIN_LOW;
      potential            = 0;
      forward              = 1'b1;
      cycles_done          = 0;
      run_active           = 1'b0;
      held_current         = 0;
      errors               = 0;
      checked              = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_SWEEP_MODE:  settings.sweep_mode  = d[1:0];
        CFG_START_UV:    settings.start_uv    = d;
        CFG_TARGET_UV:   settings.target_uv   = d;
        CFG_STEP_UV:     settings.step_uv     = d[19:0];
        CFG_INITIAL_UV:  settings.initial_uv  = d;
        CFG_CYCLE_LIMIT: settings.cycle_limit = d[7:0];
        CFG_GAIN_RANGE:  settings.gain_range  = d[1:0];
        default: ;
      endcase
    endfunction

    // Division with rounding half away from zero; d is positive.
    function longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    // Applies one accepted request; returns 1 when it is due to give a report.
    function bit take_request(logic action, logic [15:0] code);
      longint        lo, hi, stp, num, dac, mv, c;
      sweep_report_t r;
      lo  = $signed(settings.start_uv);
      hi  = $signed(settings.target_uv);
      stp = settings.step_uv;
      c   = code;
      if (action == ACT_START) begin
        potential   = $signed(settings.initial_uv);
        forward     = 1'b1;
        cycles_done = 0;
        run_active  = 1'b1;
        return 1'b0;
      end
      if (!run_active) return 1'b0;

      // Setpoint and millivolts describe the potential before this step.
      dac = 2700000 - potential;
      mv  = round_div(potential, 1000);
      if (mv > 4095) mv = 4095;
      if (mv < -4096) mv = -4096;

      if (settings.sweep_mode == MODE_LINEAR || settings.sweep_mode == MODE_CYCLIC) begin
        // Eight times (2.5 V - code * 78.125 uV), so the code scale stays integral.
        num = 20000000 - 625 * c;
        case (settings.gain_range)
          GAIN_LOW:  held_current = round_div(num, 8 * 15000);
          GAIN_MID:  held_current = round_div(num, 8 * 146);
          GAIN_HIGH: held_current = round_div(num, 8 * 20);
          default: ;
        endcase
        if (settings.sweep_mode == MODE_CYCLIC) begin
          if (forward) begin
            potential = potential + stp;
            if (potential > hi - 100) forward = 1'b0;
          end else begin
            potential = potential - stp;
            if (potential < lo + 100) begin
              forward     = 1'b1;
              cycles_done = (cycles_done + 1) & 255;
              if (cycles_done >= int'(settings.cycle_limit)) begin
                run_active  = 1'b0;
                cycles_done = 0;
              end
            end
          end
        end else begin
          potential = potential + stp;
          if (potential * 10000 > hi * 10001) begin
            run_active  = 1'b0;
            cycles_done = 0;
          end
        end
        if (potential > 64'sd8388607) potential = 64'sd8388607;
        if (potential < -64'sd8388608) potential = -64'sd8388608;
      end

      r.dac     = dac[23:0];
      r.mv      = mv[12:0];
      r.cur     = held_current[17:0];
      r.running = run_active;
      expected_reports.push_back(r);
      return 1'b1;
    endfunction

    function void check_report(logic [55:0] data, logic last);
      sweep_report_t got, want;
      got.dac     = data[23:0];
      got.mv      = data[36:24];
      got.cur     = data[54:37];
      got.running = ~last;
      checked++;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("report %0d arrived with none expected: dac %0d mv %0d cur %0d running %0b",
                   checked, got.dac, got.mv, got.cur, got.running);
        return;
      end
      want = expected_reports.pop_front();
      if (got.dac !== want.dac || got.mv !== want.mv || got.cur !== want.cur ||
          got.running !== want.running) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("report %0d mismatch (exp/got): dac %0d/%0d mv %0d/%0d cur %0d/%0d run %0b/%0b",
                   checked, want.dac, got.dac, want.mv, got.mv, want.cur, got.cur,
                   want.running, got.running);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // [15:0] adc_code
  logic [0:0]            s_axis_tuser = '0;   // [0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [55:0]           m_axis_tdata;        // [23:0] dac, [36:24] mv, [54:37] current
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sweep_checker sweep_chk;

  // Sender and receiver idling, in percent per request; changed per phase.
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int items_done = 0;
  // The long receiver hold-off: requested by the stimulus, timed by its own process.
  bit   squeeze_go = 1'b0;
  logic hold       = 1'b0;

  voltammetry_sweep_sequencer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_pct();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return 0;
    if (r == 1) return 15;
    return 50;
  endfunction

  function automatic logic [15:0] rand_code();
    int          r;
    logic [31:0] w;
    r = $urandom_range(0, 9);
    w = $urandom();
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return w[15:0];
  endfunction

  function automatic cfg_t make_cfg(logic [1:0] mode, int lo, int hi, int stp, int init,
                                    int limit, logic [1:0] gain);
    cfg_t c;
    c.sweep_mode  = mode;
    c.start_uv    = lo[22:0];
    c.target_uv   = hi[22:0];
    c.step_uv     = stp[19:0];
    c.initial_uv  = init[22:0];
    c.cycle_limit = limit[7:0];
    c.gain_range  = gain;
    return c;
  endfunction

  // Random settings, biased toward narrow windows and coarse steps so that
  // runs turn and end within a few dozen samples.
  function automatic cfg_t rand_cfg();
    int         r, lo, hi, span, base, init, stp, limit, tmp;
    logic [1:0] mode;
    r = $urandom_range(0, 9);
    if (r < 4) mode = MODE_CYCLIC;
    else if (r < 8) mode = MODE_LINEAR;
    else if (r == 8) mode = MODE_REPORT;
    else mode = MODE_REPORT_ALT;

    lo = int'($urandom_range(0, 8000000)) - 4000000;
    r  = $urandom_range(0, 9);
    if (r < 4) span = $urandom_range(0, 2000);
    else if (r < 8) span = $urandom_range(0, 500000);
    else span = $urandom_range(0, 8000000);
    hi = (lo + span > 4000000) ? 4000000 : lo + span;
    // Now and then the turning points are given the wrong way round.
    if ($urandom_range(0, 9) == 0) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end

    r = $urandom_range(0, 9);
    if (r == 0) stp = 0;
    else if (r == 1) stp = 1000000;
    else begin
      stp = span / int'($urandom_range(1, 12)) + int'($urandom_range(0, 50));
      if (stp > 1000000) stp = 1000000;
    end

    base = (lo < hi) ? lo : hi;
    if ($urandom_range(0, 9) < 7)
      init = base + int'($urandom_range(0, (lo < hi) ? hi - lo : lo - hi));
    else
      init = int'($urandom_range(0, 8000000)) - 4000000;

    r = $urandom_range(0, 9);
    if (r < 6) limit = $urandom_range(0, 3);
    else if (r < 8) limit = $urandom_range(4, 10);
    else if (r == 8) limit = 255;
    else limit = $urandom_range(0, 255);

    return make_cfg(mode, lo, hi, stp, init, limit, 2'($urandom_range(0, 3)));
  endfunction

  // One register write; the caller lowers cfg_valid after the last of a batch.
  task automatic cfg_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sweep_chk.set_reg(idx, d);
  endtask

  task automatic apply_cfg(cfg_t c);
    cfg_write(CFG_SWEEP_MODE, CFG_DATA_W'(c.sweep_mode));
    cfg_write(CFG_START_UV, c.start_uv);
    cfg_write(CFG_TARGET_UV, c.target_uv);
    cfg_write(CFG_STEP_UV, CFG_DATA_W'(c.step_uv));
    cfg_write(CFG_INITIAL_UV, c.initial_uv);
    cfg_write(CFG_CYCLE_LIMIT, CFG_DATA_W'(c.cycle_limit));
    cfg_write(CFG_GAIN_RANGE, CFG_DATA_W'(c.gain_range));
    cfg_valid <= 1'b0;
  endtask

  // Offers one request, sometimes after a random pause, and waits for it to be taken.
  // Ignored samples do not count toward the item total.
  task automatic send_item(logic action, logic [15:0] code);
    int pause;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      pause = pause_len();
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tuser[0] <= action;
    s_axis_tdata    <= code;
    do @(posedge clk); while (!s_axis_tready);
    if (sweep_chk.take_request(action, code) || action == ACT_START) items_done++;
  endtask

  // Lets every expected report come out, plus the pipeline depth, so that
  // registers can be changed with nothing in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sweep_chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: check every accepted report, then decide whether to stall.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sweep_chk.check_report(m_axis_tdata, m_axis_tlast);
      if (hold) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = pause_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // The long hold-off: the receiver stops while the sender keeps offering
  // samples, so the pipeline fills and the input side has to back off.
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("voltammetry_sweep_sequencer test failed");
    $finish;
  end

  initial begin
    int budget;
    int runs;
    sweep_chk = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: mode 0 only reports. A sample before any start is
    // dropped; after the start the held current of zero is reported and the
    // potential does not move.
    send_item(ACT_SAMPLE, 16'h1234);
    send_item(ACT_START, 16'h0000);
    send_item(ACT_SAMPLE, 16'h0000);
    send_item(ACT_SAMPLE, 16'hFFFF);
    settle();

    // Linear ramp across the whole potential range in the highest gain
    // range, with both code extremes and the exact mid-scale code (32000).
    // The ninth sample ends the run; the sample after it is dropped.
    apply_cfg(make_cfg(MODE_LINEAR, -4000000, 4000000, 1000000, -4000000, 0, GAIN_HIGH));
    send_item(ACT_START, 16'h0000);
    send_item(ACT_SAMPLE, 16'h0000);
    send_item(ACT_SAMPLE, 16'hFFFF);
    send_item(ACT_SAMPLE, 16'd32000);
    send_item(ACT_SAMPLE, 16'h0001);
    send_item(ACT_SAMPLE, 16'hFFFE);
    send_item(ACT_SAMPLE, 16'h5555);
    send_item(ACT_SAMPLE, 16'hAAAA);
    send_item(ACT_SAMPLE, 16'h3039);
    send_item(ACT_SAMPLE, 16'h9C40);
    send_item(ACT_SAMPLE, 16'h7FFF);
    settle();

    // Cyclic run below the lower turning point with the hold range: the
    // potential starts on a half millivolt, finishes one cycle of two, swings
    // past -4.096 V so the millivolt field clips, then a start restarts it.
    apply_cfg(make_cfg(MODE_CYCLIC, -4000000, -3000000, 1000000, -3500500, 2, GAIN_HOLD));
    send_item(ACT_START, 16'h0000);
    send_item(ACT_SAMPLE, 16'h8000);
    send_item(ACT_SAMPLE, 16'h0000);
    send_item(ACT_SAMPLE, 16'hFFFF);
    send_item(ACT_SAMPLE, 16'h4000);
    send_item(ACT_START, 16'hFFFF);
    send_item(ACT_SAMPLE, 16'h1111);
    send_item(ACT_SAMPLE, 16'hEEEE);
    settle();

    // Upper turn in the middle range: the overshoot past 4.095 V clips the
    // millivolt field high, and 3999.5 mV rounds up.
    apply_cfg(make_cfg(MODE_CYCLIC, 0, 4000000, 1000000, 3999500, 1, GAIN_MID));
    send_item(ACT_START, 16'h0000);
    send_item(ACT_SAMPLE, 16'h2345);
    send_item(ACT_SAMPLE, 16'hC001);
    settle();

    // A long cyclic run with no sender gaps while the receiver holds off.
    gap_pct = 0;
    apply_cfg(make_cfg(MODE_CYCLIC, -1000000, 1000000, 10000, 0, 255, GAIN_LOW));
    send_item(ACT_START, rand_code());
    squeeze_go = 1'b1;
    budget = 200;
    while (sweep_chk.run_active && budget > 0) begin
      send_item(ACT_SAMPLE, rand_code());
      budget--;
    end
    settle();

    // Random phases: mostly whole runs of samples with random codes, with an
    // occasional restart in mid-run and stray samples after a run has ended.
    while (items_done < ITEM_TARGET) begin
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      apply_cfg(rand_cfg());
      runs = $urandom_range(1, 3);
      repeat (runs) begin
        send_item(ACT_START, rand_code());
        budget = $urandom_range(5, 80);
        while (sweep_chk.run_active && budget > 0) begin
          if ($urandom_range(0, 99) < 2) send_item(ACT_START, rand_code());
          else send_item(ACT_SAMPLE, rand_code());
          budget--;
        end
        if ($urandom_range(0, 3) == 0) send_item(ACT_SAMPLE, rand_code());
      end
      settle();
    end

    if (sweep_chk.errors == 0 && sweep_chk.pending() == 0) begin
      $display("voltammetry_sweep_sequencer test passed");
    end else begin
      $display("voltammetry_sweep_sequencer test failed");
    end
    $finish;
  end

endmodule
